// ===== hdl/cirm_pkg.sv =====
`timescale 1ns / 1ps

package cirm_pkg;

	// Sizes of the physical ID spaces and of the logical ID.
	localparam int DISCARD_IDS  = 4096;
	localparam int DEGRADE_IDS  = 4096;
	localparam int LOGICAL_BITS = 20;

	localparam int LIMIT_BITS  = 12;
	localparam int WINDOW_BITS = 7;
	localparam int MAXPHYS_BITS = 13;
	localparam int TBL_DEPTH   = DISCARD_IDS;
	localparam int TBL_AW      = $clog2(TBL_DEPTH);
	localparam int TBL_DW      = 8;

	localparam logic [LIMIT_BITS-1:0]   DEGRADE_LIMIT_MAX = LIMIT_BITS'(DEGRADE_IDS - 2);
	localparam logic [LIMIT_BITS-1:0]   DISCARD_LIMIT_MAX = LIMIT_BITS'(DISCARD_IDS - 2);
	localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET       = 12'd4094;
	localparam logic [MAXPHYS_BITS-1:0] SAFETY_MARGIN     = 13'd2;
	localparam logic [WINDOW_BITS-1:0]  WINDOW_CAP        = 7'd127;
	localparam logic [TBL_DW-1:0]       TBL_EMPTY         = 8'hFF;

	// Configuration register indexes.
	localparam logic [0:0] REG_DEGRADE_LIMIT = 1'b0;
	localparam logic [0:0] REG_DISCARD_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		OP_DEGRADE = 2'd0,
		OP_DISCARD = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STS_OK            = 3'd0,
		STS_AFTER_RELEASE = 3'd1,
		STS_WIN_OVERFLOW  = 3'd2,
		STS_ABOVE_MAX     = 3'd3,
		STS_WIN_AHEAD     = 3'd4
	} status_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [TBL_DW-1:0] data;
	} tbl_wr_t;

endpackage

// ===== hdl/cirm_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module cirm_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [cirm_pkg::LOGICAL_BITS-1:0]  dividend,
	input  logic [cirm_pkg::LIMIT_BITS-1:0]    divisor,
	output cirm_pkg::div_stat_t                stat,
	output logic [cirm_pkg::LOGICAL_BITS-1:0]  quotient,
	output logic [cirm_pkg::LIMIT_BITS-1:0]    remainder
);
	import cirm_pkg::*;

	localparam int CNT_BITS = $clog2(LOGICAL_BITS);

	logic [LIMIT_BITS-1:0]   rem_q;
	logic [LOGICAL_BITS-1:0] quo_q;
	logic [LIMIT_BITS-1:0]   dvs_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [LIMIT_BITS:0] trial;
	logic [LIMIT_BITS:0] diff;
	logic                fits;

	assign trial = {rem_q, quo_q[LOGICAL_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(LOGICAL_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[LIMIT_BITS-1:0] : trial[LIMIT_BITS-1:0];
			quo_q <= {quo_q[LOGICAL_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/cirm_table.sv =====
`timescale 1ns / 1ps

// Last releasing window per physical ID. After reset a sweep writes the
// empty marker into every entry; ready stays low until it is through.
module cirm_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [cirm_pkg::TBL_AW-1:0]  rd_addr,
	output logic [cirm_pkg::TBL_DW-1:0]  rd_data,
	input  cirm_pkg::tbl_wr_t            wr,
	output logic                         ready
);
	import cirm_pkg::*;

	logic [TBL_DW-1:0] mem [TBL_DEPTH];
	logic [TBL_AW-1:0] clr_addr_q;
	logic              clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {TBL_AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= TBL_EMPTY;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign ready = !clearing_q;

endmodule

// ===== hdl/cache_id_rollover_mapper.sv =====
`timescale 1ns / 1ps

// Rollover mapper for cache-maintenance IDs.
//
// Input transactions arrive on the s_axis group: tuser carries the operation
// (degrade convert, discard convert, release discard), tdata the logical ID
// and the current rollover window. Each input transaction yields exactly one
// output transaction on the m_axis group with the physical ID, the rollover
// window, the change-to-degrade flag, a status code and the maximum physical
// IDs in use. The limits are to be written through the cfg port while idle.
//
// Items are handled one at a time: a new item is taken only in the idle
// state, after the previous one has left the decision step. Each item passes
// the 20-step divider that forms (id-1)/limit and (id-1)%limit, waits for its
// done flag, and then goes through the table read and the decision.
//
// After reset the block clears its 4096-entry release-window table, one entry
// per cycle, and s_axis_tready stays low until it is done. The block does not
// enforce the idle rule; configuration writes are taken during the clear too.
// The result sits in an output register; the block accepts the next item while
// it waits and holds its decision until the receiver has taken the last result.
module cache_id_rollover_mapper (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // logical_id[19:0], current_window[26:20]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// physical_id[11:0], rollover_window[18:12], change_to_degrade[19],
	// status[22:20], max_physical_degrade[35:23], max_physical_discard[48:36]
	output logic [55:0] m_axis_tdata
);
	import cirm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DIV    = 4'b0010,
		S_READ   = 4'b0100,
		S_DECIDE = 4'b1000
	} fsm_t;

	fsm_t state_q;

	// Configuration and architectural state.
	logic [LIMIT_BITS-1:0]   deg_lim_q;
	logic [LIMIT_BITS-1:0]   dis_lim_q;
	logic [LOGICAL_BITS-1:0] max_dg_q;
	logic [LOGICAL_BITS-1:0] max_ds_q;
	logic                    rps_q;

	// The item in flight.
	op_t                     op_q;
	logic [LOGICAL_BITS-1:0] lid_q;
	logic [WINDOW_BITS-1:0]  cur_q;

	// Output register.
	logic        m_valid_q;
	logic [55:0] m_data_q;

	logic [LIMIT_BITS-1:0] dgl;
	logic [LIMIT_BITS-1:0] dsl;

	// Clamp a limit register into 1 .. max.
	function automatic logic [LIMIT_BITS-1:0] clamp_limit(
		input logic [LIMIT_BITS-1:0] val,
		input logic [LIMIT_BITS-1:0] lim_max
	);
		logic [LIMIT_BITS-1:0] res;
		if (val == '0) begin
			res = LIMIT_BITS'(1);
		end else if (val > lim_max) begin
			res = lim_max;
		end else begin
			res = val;
		end
		return res;
	endfunction

	// Highest physical ID in use: zero when nothing was seen yet.
	function automatic logic [MAXPHYS_BITS-1:0] max_physical(
		input logic [LOGICAL_BITS-1:0] max_log,
		input logic [LIMIT_BITS-1:0]   lim
	);
		logic [MAXPHYS_BITS-1:0] res;
		if (max_log == '0) begin
			res = '0;
		end else if (max_log < LOGICAL_BITS'(lim)) begin
			res = MAXPHYS_BITS'(max_log[LIMIT_BITS-1:0]) + SAFETY_MARGIN;
		end else begin
			res = MAXPHYS_BITS'(lim) + SAFETY_MARGIN;
		end
		return res;
	endfunction

	assign dgl = clamp_limit(deg_lim_q, DEGRADE_LIMIT_MAX);
	assign dsl = clamp_limit(dis_lim_q, DISCARD_LIMIT_MAX);

	// Handshakes.
	logic tbl_ready;
	logic accept;
	logic out_free;
	logic commit;

	assign s_axis_tready = tbl_ready && (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign commit        = (state_q == S_DECIDE) && out_free;

	// Divider: (id-1) by the limit of the operation.
	div_stat_t               div_stat;
	logic [LOGICAL_BITS-1:0] div_quot;
	logic [LIMIT_BITS-1:0]   div_rem;
	logic [LOGICAL_BITS-1:0] in_lid;
	logic                    in_is_degrade;

	assign in_lid        = s_axis_tdata[LOGICAL_BITS-1:0];
	assign in_is_degrade = op_t'(s_axis_tuser) == OP_DEGRADE;

	cirm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (in_lid - LOGICAL_BITS'(1)),
		.divisor   (in_is_degrade ? dgl : dsl),
		.stat      (div_stat),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Release-window table, read at the mapped physical ID.
	logic [TBL_AW-1:0] phys_p;
	logic [TBL_DW-1:0] tbl_rd_data;
	tbl_wr_t           tbl_wr;
	logic              tbl_we_d;

	assign phys_p = TBL_AW'(div_rem) + TBL_AW'(1);

	cirm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == S_READ),
		.rd_addr (phys_p),
		.rd_data (tbl_rd_data),
		.wr      (tbl_wr),
		.ready   (tbl_ready)
	);

	assign tbl_wr.en   = commit && tbl_we_d;
	assign tbl_wr.addr = phys_p;
	assign tbl_wr.data = TBL_DW'(cur_q);

	// Decision for the item in flight. The table entry is a signed window,
	// with minus one meaning that the ID was never released.
	logic [LIMIT_BITS-1:0]  phys_d;
	logic [WINDOW_BITS-1:0] win_d;
	logic                   chg_d;
	status_t                status_d;
	logic                   upd_dg;
	logic                   upd_ds;
	logic                   set_rps;
	logic                   lid_nz;
	logic [TBL_DW:0]        last9;
	logic [TBL_DW:0]        rw9;

	assign lid_nz = lid_q != '0;
	assign last9  = {tbl_rd_data[TBL_DW-1], tbl_rd_data};
	assign rw9    = (TBL_DW+1)'(div_quot[WINDOW_BITS-1:0]);

	always_comb begin
		phys_d   = '0;
		win_d    = '0;
		chg_d    = 1'b0;
		status_d = STS_OK;
		upd_dg   = 1'b0;
		upd_ds   = 1'b0;
		set_rps  = 1'b0;
		tbl_we_d = 1'b0;
		case (op_q)
			OP_DEGRADE: begin
				upd_dg = lid_q > max_dg_q;
				if (lid_nz) begin
					phys_d = phys_p;
				end
			end
			OP_DISCARD: begin
				if (rps_q) begin
					status_d = STS_AFTER_RELEASE;
				end else if (lid_nz && div_quot >= LOGICAL_BITS'(WINDOW_CAP)) begin
					status_d = STS_WIN_OVERFLOW;
					win_d    = WINDOW_CAP;
				end else begin
					upd_ds = lid_q > max_ds_q;
					if (lid_nz) begin
						phys_d = phys_p;
						win_d  = div_quot[WINDOW_BITS-1:0];
					end
				end
			end
			OP_RELEASE: begin
				if (lid_q > max_ds_q) begin
					status_d = STS_ABOVE_MAX;
				end else if (!lid_nz) begin
					set_rps = 1'b1;
				end else if (max_ds_q <= LOGICAL_BITS'(dsl)) begin
					set_rps = 1'b1;
					phys_d  = phys_p;
				end else if (div_quot > LOGICAL_BITS'(cur_q)) begin
					status_d = STS_WIN_AHEAD;
				end else begin
					// The window is at most the current one here, so it fits
					// in the window width.
					set_rps = 1'b1;
					phys_d  = phys_p;
					chg_d   = div_quot[WINDOW_BITS-1:0] < cur_q;
					if (last9 + (TBL_DW+1)'(1) == rw9) begin
						tbl_we_d = 1'b1;
					end else if ($signed(last9) < $signed(rw9)) begin
						chg_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Values after the item, for the max fields.
	logic [LOGICAL_BITS-1:0] next_max_dg;
	logic [LOGICAL_BITS-1:0] next_max_ds;

	assign next_max_dg = upd_dg ? lid_q : max_dg_q;
	assign next_max_ds = upd_ds ? lid_q : max_ds_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_axis_tuser);
			lid_q <= in_lid;
			cur_q <= s_axis_tdata[LOGICAL_BITS +: WINDOW_BITS];
		end
	end

	// Configuration registers and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_lim_q <= LIMIT_RESET;
			dis_lim_q <= LIMIT_RESET;
			max_dg_q  <= '0;
			max_ds_q  <= '0;
			rps_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DEGRADE_LIMIT: deg_lim_q <= cfg_data;
					REG_DISCARD_LIMIT: dis_lim_q <= cfg_data;
				endcase
			end
			if (commit) begin
				max_dg_q <= next_max_dg;
				max_ds_q <= next_max_ds;
				if (set_rps) begin
					rps_q <= 1'b1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= {7'd0,
				max_physical(next_max_ds, dsl),
				max_physical(next_max_dg, dgl),
				status_d, chg_d, win_d, phys_d};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// An accepted item always starts the divider.
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> div_stat.busy)
		else $error("divider not busy after accepted transaction");

	// Only windows up to the current one are stored, never the empty marker.
	a_tbl_wr_window: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> (tbl_wr.data[TBL_DW-1] == 1'b0) && (op_q == OP_RELEASE))
		else $error("bad release-window table write");

	// No item is taken while the table is still being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!tbl_ready |-> !s_axis_tready)
		else $error("input taken during table clear");

	// The decision only follows a table read.
	a_decide_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_DECIDE) |-> $past(state_q == S_READ))
		else $error("decision without table read");

endmodule
